### rtl/core/itda_pkg.sv
package itda_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W = 4 * NUM_DIGITS;
	localparam int unsigned STEPS_PER_STAGE = 8;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned MAX_CHARS = 11;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	localparam logic MODE_SIGNED = 1'b0;
	localparam logic MODE_UNSIGNED = 1'b1;

	// Conversion state handed from stage to stage
	typedef struct packed {
		logic neg;
		logic [BCD_W-1:0] bcd;
		logic [WORD_W-1:0] bin;
	} dab_t;

	// One double-dabble step: correct every digit, then shift in the next bit
	function automatic dab_t dabble_step(input dab_t d);
		dab_t r;
		logic [BCD_W-1:0] adj;
		adj = d.bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (adj[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
			end
		end
		r.neg = d.neg;
		r.bcd = {adj[BCD_W-2:0], d.bin[WORD_W-1]};
		r.bin = {d.bin[WORD_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

### rtl/core/itda_dabble.sv
module itda_dabble (
	input  itda_pkg::dab_t d_in,
	output itda_pkg::dab_t d_out
);

	// Eight chained steps of the binary-to-BCD shift
	always_comb begin
		itda_pkg::dab_t t;
		t = d_in;
		for (int k = 0; k < itda_pkg::STEPS_PER_STAGE; k++) begin
			t = itda_pkg::dabble_step(t);
		end
		d_out = t;
	end

endmodule

### rtl/core/itda_serial.sv
module itda_serial (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  itda_pkg::dab_t load_data,
	output logic ready,
	output logic strobe,
	output logic [7:0] ascii_char,
	output logic [3:0] char_count,
	output logic is_last
);

	logic active_q;
	logic neg_q;
	logic [itda_pkg::BCD_W-1:0] digits_q;
	logic [itda_pkg::CNT_W-1:0] rem_q;
	logic [itda_pkg::CNT_W-1:0] cnt_q;

	logic [itda_pkg::CNT_W-1:0] ndig;
	logic [itda_pkg::CNT_W-1:0] shift_dig;
	logic [itda_pkg::BCD_W-1:0] aligned;
	logic last_now;

	// Count significant digits; zero still prints one digit
	always_comb begin
		ndig = itda_pkg::CNT_W'(1);
		for (int i = 1; i < itda_pkg::NUM_DIGITS; i++) begin
			if (load_data.bcd[4*i +: 4] != 4'd0) begin
				ndig = itda_pkg::CNT_W'(i + 1);
			end
		end
		shift_dig = itda_pkg::CNT_W'(itda_pkg::NUM_DIGITS) - ndig;
		aligned = load_data.bcd << {shift_dig, 2'b00};
	end

	assign last_now = active_q && (rem_q == itda_pkg::CNT_W'(1));
	assign ready = !active_q || last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (ready) begin
			active_q <= load;
			if (load) begin
				neg_q <= load_data.neg;
				rem_q <= ndig + itda_pkg::CNT_W'(load_data.neg);
				cnt_q <= itda_pkg::CNT_W'(1);
			end
		end else begin
			// advance to the next character
			rem_q <= rem_q - itda_pkg::CNT_W'(1);
			cnt_q <= cnt_q + itda_pkg::CNT_W'(1);
			neg_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready) begin
			if (load) begin
				digits_q <= aligned;
			end
		end else if (!neg_q) begin
			digits_q <= {digits_q[itda_pkg::BCD_W-5:0], 4'd0};
		end
	end

	assign strobe = active_q;
	assign ascii_char = neg_q ? itda_pkg::ASCII_MINUS
		: (itda_pkg::ASCII_ZERO | {4'd0, digits_q[itda_pkg::BCD_W-1 -: 4]});
	assign char_count = cnt_q;
	assign is_last = last_now;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (rem_q != 4'd0 && rem_q <= 4'd11))
		else $error("character run length out of range");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && rem_q != 4'd1) |=> active_q)
		else $error("character run ended early");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && rem_q != 4'd1) |=> (cnt_q == $past(cnt_q) + 4'd1))
		else $error("character count did not advance");

	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && neg_q) |-> (cnt_q == 4'd1))
		else $error("minus sign not first character");

endmodule

### rtl/core/int_to_decimal_ascii.sv
// A request passes stages s1 to s5 and is loaded into the character sequencer;
// it then puts out one character per cycle, 1 to 11 characters per request.
// Throughput: a request may be taken every cycle while the pipeline has room; the
// sustained rate is one request per character run, set by the single result port.
// Reset clears all valid bits and the character sequencer; no result follows reset.
module int_to_decimal_ascii (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cmd,
	input  logic [31:0] value,
	output logic strobe,
	output logic [7:0] ascii_char,
	output logic [3:0] char_count,
	output logic is_last
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	itda_pkg::dab_t data_s1, data_s2, data_s3, data_s4, data_s5;
	itda_pkg::dab_t dab_out1, dab_out2, dab_out3, dab_out4;
	itda_pkg::dab_t in_data;
	logic ser_ready;
	logic stall;

	assign stall = valid_s5 && !ser_ready;
	assign busy = stall;

	// Negate signed negative words; the most negative one wraps to its own magnitude
	always_comb begin
		in_data.neg = (cmd == itda_pkg::MODE_SIGNED) && value[31];
		in_data.bcd = '0;
		in_data.bin = in_data.neg ? (~value + 32'd1) : value;
	end

	itda_dabble u_dab1 (.d_in(data_s1), .d_out(dab_out1));
	itda_dabble u_dab2 (.d_in(data_s2), .d_out(dab_out2));
	itda_dabble u_dab3 (.d_in(data_s3), .d_out(dab_out3));
	itda_dabble u_dab4 (.d_in(data_s4), .d_out(dab_out4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Hold every stage while the sequencer cannot take the oldest request
	always_ff @(posedge clk) begin
		if (!stall) begin
			data_s1 <= in_data;
			data_s2 <= dab_out1;
			data_s3 <= dab_out2;
			data_s4 <= dab_out3;
			data_s5 <= dab_out4;
		end
	end

	itda_serial u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s5),
		.load_data(data_s5),
		.ready(ser_ready),
		.strobe(strobe),
		.ascii_char(ascii_char),
		.char_count(char_count),
		.is_last(is_last)
	);

	a_busy_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s5)
		else $error("busy without a waiting request");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (valid_s5 && data_s5 == $past(data_s5)))
		else $error("stalled request changed");

	a_strobe_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && !stall) |=> (strobe && char_count == 4'd1))
		else $error("loaded request did not start a run");

endmodule
